// File: sv/assert_macros.svh
// Assertion macros shared by the verifier RTL.
// Depends on nothing; each using module provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BICV_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define BICV_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define BICV_ASSERT(lbl, pre, post)
`define BICV_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: sv/bicv_pkg.sv
// Types, constants and the CRC byte update for the banked image CRC verifier.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package bicv_pkg;

  localparam int MaxRegions = 8;
  localparam int HeaderSize = 16;

  typedef enum logic [1:0] {
    REG_COMMON_LENGTH = 2'd0,
    REG_SKIP_OFFSET   = 2'd1,
    REG_BANK_LENGTH   = 2'd2,
    REG_BANK_COUNT    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] common_length;
    logic [15:0] skip_offset;
    logic [15:0] bank_length;
    logic [3:0]  bank_count;
  } cfg_t;

  // Word held in the input register, handed to the region controller.
  typedef struct packed {
    logic       fire;
    logic [7:0] image_byte;
    logic       restart;
  } step_t;

  typedef struct packed {
    logic [2:0]  region_index;
    logic [15:0] computed_crc;
    logic [15:0] stored_crc;
    logic        crc_match;
    logic        image_good;
  } result_t;

  // Reflected CCITT update of one byte (Kermit form).
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ (d << 4);
    return {d, crc[15:8]} ^ {12'd0, d[7:4]} ^ {5'd0, d, 3'd0};
  endfunction

endpackage
`default_nettype wire

// File: sv/banked_image_crc_verifier.sv
// Banked boot-image CRC verifier: one image byte per cycle in, one result word per
// region out. A byte is registered on entry; the region logic then updates the CRC
// and counters from the registered byte and loads the result register. The block
// takes a byte in every cycle; the only thing that stalls the byte side is a result
// waiting in the output register while the next registered byte would close another
// region.
// Depends on bicv_pkg, bicv_cfg_regs, bicv_region_ctrl and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module banked_image_crc_verifier import bicv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [7:0]  image_byte,
  input  wire logic        restart,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [2:0]       region_index,
  output logic [15:0]      computed_crc,
  output logic [15:0]      stored_crc,
  output logic             crc_match,
  output logic             image_good
);

  cfg_t    cfg;
  step_t   step;
  result_t res;
  logic    emit;
  logic    s1_valid;
  logic [7:0] s1_byte;
  logic    s1_restart;
  logic    out_free;

  bicv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bicv_region_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .emit   (emit),
    .result (res)
  );

  assign out_free        = !result_valid || !result_stall;
  assign step.fire       = s1_valid && (out_free || !emit);
  assign step.image_byte = s1_byte;
  assign step.restart    = s1_restart;
  assign item_stall      = s1_valid && !step.fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_byte    <= image_byte;
      s1_restart <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step.fire && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire && emit) begin
      region_index <= res.region_index;
      computed_crc <= res.computed_crc;
      stored_crc   <= res.stored_crc;
      crc_match    <= res.crc_match;
      image_good   <= res.image_good;
    end
  end

  `BICV_ASSERT(a_stall_cause, item_stall, result_valid && result_stall && emit)
  `BICV_ASSERT(a_good_needs_match, result_valid, !image_good || crc_match)
  `BICV_ASSERT_NEXT(a_emit_shows, step.fire && emit, result_valid)

endmodule
`default_nettype wire

// File: sv/bicv_cfg_regs.sv
// Configuration registers of the verifier, written through a valid/ready port.
// Depends on bicv_pkg.
`default_nettype none
module bicv_cfg_regs import bicv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.common_length <= 16'd57344;
      cfg.skip_offset   <= 16'd256;
      cfg.bank_length   <= 16'd32768;
      cfg.bank_count    <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_COMMON_LENGTH: cfg.common_length <= cfg_data;
        REG_SKIP_OFFSET:   cfg.skip_offset   <= cfg_data;
        REG_BANK_LENGTH:   cfg.bank_length   <= cfg_data;
        REG_BANK_COUNT:    cfg.bank_count    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/bicv_region_ctrl.sv
// Region tracking, header capture and per-region CRC of the verifier.
// Depends on bicv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bicv_region_ctrl import bicv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire step_t step,
  output logic       emit,
  output result_t    result
);

  logic [15:0] byte_position, byte_position_next;
  logic [2:0]  current_region, current_region_next;
  logic [15:0] running_crc, running_crc_next;
  logic        halted, halted_next;

  // Header kept as even and odd bytes so each half is read at one address.
  logic [7:0] header_even [HeaderSize/2];
  logic [7:0] header_odd  [HeaderSize/2];

  logic [15:0] pos_e, crc_e, crc_upd, last_pos;
  logic [2:0]  region_e;
  logic        halt_e;
  logic [3:0]  region_total, region_plus;
  logic        hdr_write;
  logic [7:0]  hdr_lo, hdr_hi;
  logic        match;

  always_comb begin
    pos_e    = step.restart ? 16'd0 : byte_position;
    region_e = step.restart ? 3'd0  : current_region;
    crc_e    = step.restart ? 16'd0 : running_crc;
    halt_e   = step.restart ? 1'b0  : halted;

    if (cfg.bank_count == 4'd0) begin
      region_total = 4'd1;
    end else if (cfg.bank_count > 4'(MaxRegions)) begin
      region_total = 4'(MaxRegions);
    end else begin
      region_total = cfg.bank_count;
    end
    region_plus = {1'b0, region_e} + 4'd1;

    if (region_e == 3'd0) begin
      crc_upd  = (pos_e >= cfg.skip_offset) ? crc_byte(crc_e, step.image_byte) : crc_e;
      last_pos = cfg.common_length - 16'd1;
    end else begin
      crc_upd  = crc_byte(crc_e, step.image_byte);
      last_pos = cfg.bank_length - 16'd1;
    end
    hdr_write = !halt_e && (region_e == 3'd0) && (pos_e < 16'(HeaderSize));

    // A very short common region can close on the header byte that it reads.
    hdr_lo = (hdr_write && pos_e[3:0] == {region_e, 1'b0}) ? step.image_byte
                                                          : header_even[region_e];
    hdr_hi = (hdr_write && pos_e[3:0] == {region_e, 1'b1}) ? step.image_byte
                                                          : header_odd[region_e];

    result.region_index = region_e;
    result.computed_crc = crc_upd;
    result.stored_crc   = {hdr_hi, hdr_lo};
    match               = (result.stored_crc == crc_upd);
    result.crc_match    = match;
    result.image_good   = match && (region_plus >= region_total);

    emit = !halt_e && (pos_e == last_pos);

    byte_position_next  = pos_e;
    current_region_next = region_e;
    running_crc_next    = crc_e;
    halted_next         = halt_e;
    if (!halt_e) begin
      if (pos_e != last_pos) begin
        byte_position_next = pos_e + 16'd1;
        running_crc_next   = crc_upd;
      end else begin
        byte_position_next  = 16'd0;
        running_crc_next    = 16'd0;
        current_region_next = region_plus[2:0];
        halted_next = !match || (region_plus[2:0] == 3'd0) ||
                      ({1'b0, region_plus[2:0]} >= region_total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= 16'd0;
      current_region <= 3'd0;
      running_crc    <= 16'd0;
      halted         <= 1'b0;
    end else if (step.fire) begin
      byte_position  <= byte_position_next;
      current_region <= current_region_next;
      running_crc    <= running_crc_next;
      halted         <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire && hdr_write) begin
      if (pos_e[0]) begin
        header_odd[pos_e[3:1]] <= step.image_byte;
      end else begin
        header_even[pos_e[3:1]] <= step.image_byte;
      end
    end
  end

  `BICV_ASSERT(a_halt_quiet, step.fire && halted && !step.restart, !emit)
  `BICV_ASSERT_NEXT(a_mismatch_halts, step.fire && emit && !result.crc_match, halted)
  `BICV_ASSERT_NEXT(a_good_halts, step.fire && emit && result.image_good, halted)

endmodule
`default_nettype wire

// File: tb/sv/bicv_crc_checker.sv
`timescale 1ns / 100ps
// Checker for the banked image CRC verifier: follows the register, byte and result channels,
// predicts every region report and compares the reports that come out, field by field.
// Depends on bicv_pkg for the register codes, the result word layout and the region limits.
module bicv_crc_checker import bicv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [7:0]  image_byte,
  input  logic        restart,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [2:0]  region_index,
  input  logic [15:0] computed_crc,
  input  logic [15:0] stored_crc,
  input  logic        crc_match,
  input  logic        image_good,
  output int          reports_outstanding,
  output int          fail_count
);

  logic [15:0] common_bytes;
  logic [15:0] skip_len;
  logic [15:0] bank_len;
  logic [3:0]  bank_cnt;

  logic [15:0] byte_pos;
  logic [2:0]  region;
  logic [15:0] region_crc;
  logic [7:0]  header [HeaderSize];
  logic        halted;

  result_t     pending_reports [$];
  int          fails;

  // Bitwise form of the reflected CCITT update: LSB first against 0x8408.
  function automatic logic [15:0] kermit_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  // Advances the image state by one word and queues the report of a region that closes.
  task automatic track_image_byte(input logic [7:0] b, input logic first);
    logic [15:0] last_pos;
    logic [3:0]  slot;
    int          regions;
    result_t     report;
    if (first) begin
      byte_pos   = '0;
      region     = '0;
      region_crc = '0;
      halted     = 1'b0;
    end
    if (halted) return;

    if (region == 3'd0) begin
      if (byte_pos < HeaderSize) header[byte_pos[3:0]] = b;
      if (byte_pos >= skip_len) region_crc = kermit_fold(region_crc, b);
      last_pos = common_bytes - 16'd1;
    end else begin
      region_crc = kermit_fold(region_crc, b);
      last_pos = bank_len - 16'd1;
    end

    if (byte_pos != last_pos) begin
      byte_pos = byte_pos + 16'd1;
      return;
    end

    // A zero count still checks the common region; large counts clip to the limit.
    if (bank_cnt == 4'd0) regions = 1;
    else if (int'(bank_cnt) > MaxRegions) regions = MaxRegions;
    else regions = int'(bank_cnt);

    slot = {region, 1'b0};
    report.region_index = region;
    report.computed_crc = region_crc;
    report.stored_crc   = {header[slot + 4'd1], header[slot]};
    report.crc_match    = (report.stored_crc == region_crc);
    report.image_good   = report.crc_match && (int'(region) + 1 >= regions);
    pending_reports.push_back(report);

    byte_pos   = '0;
    region_crc = '0;
    region     = region + 3'd1;
    if (!report.crc_match || region == 3'd0 || int'(region) >= regions) halted = 1'b1;
  endtask

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", field, want, seen);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      common_bytes = 16'd57344;
      skip_len   = 16'd256;
      bank_len   = 16'd32768;
      bank_cnt   = 4'd8;
      byte_pos   = '0;
      region     = '0;
      region_crc = '0;
      halted     = 1'b0;
      foreach (header[i]) header[i] = '0;
      pending_reports.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_COMMON_LENGTH: common_bytes = cfg_data;
          REG_SKIP_OFFSET:   skip_len = cfg_data;
          REG_BANK_LENGTH:   bank_len = cfg_data;
          REG_BANK_COUNT:    bank_cnt = cfg_data[3:0];
          default: ;
        endcase
      end
      // A report leaves only after its closing word has passed the input register, so it is
      // always matched before a word taken at this same edge is predicted.
      if (result_valid && !result_stall) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected report for region %0d", region_index);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          compare_field("region_index", 16'(want.region_index), 16'(region_index));
          compare_field("computed_crc", want.computed_crc, computed_crc);
          compare_field("stored_crc", want.stored_crc, stored_crc);
          compare_field("crc_match", 16'(want.crc_match), 16'(crc_match));
          compare_field("image_good", 16'(want.image_good), 16'(image_good));
        end
      end
      if (item_valid && !item_stall) track_image_byte(image_byte, restart);
    end
    reports_outstanding <= pending_reports.size();
    fail_count <= fails;
  end

endmodule

// File: tb/sv/banked_image_crc_verifier_tb.sv
`timescale 1ns / 100ps
// Top of the banked image CRC verifier testbench: clock, reset, register writes, boot image
// streams with random gaps, random result stalls and the final verdict.
// Depends on bicv_pkg, the verifier RTL and bicv_crc_checker.
module banked_image_crc_verifier_tb;
  import bicv_pkg::*;

  // Legal quiet stretches come from gaps, stalls and settling; a longer one is a mismatch.
  localparam int QuietLimit = 2000;
  localparam int ItemTarget = 550;
  // Words left over for the closing images after the random phases.
  localparam int TailItems  = 300;

  localparam int FlawNone     = 0;
  localparam int FlawCorrupt  = 1;
  localparam int FlawTruncate = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_COMMON_LENGTH;
  logic [15:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [7:0]  image_byte = '0;
  logic        restart = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  region_index;
  logic [15:0] computed_crc;
  logic [15:0] stored_crc;
  logic        crc_match;
  logic        image_good;

  int reports_outstanding;
  int fail_count;

  bit calm = 1'b0;
  int gap_odds = 4;
  int quiet_cycles = 0;
  int image_bytes_sent = 0;

  // Current settings, kept here to lay out images that pass their checks.
  logic [15:0] common_bytes;
  logic [15:0] skip_len;
  logic [15:0] bank_len;
  logic [3:0]  bank_cnt;

  banked_image_crc_verifier u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .image_byte(image_byte),
    .restart(restart),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .region_index(region_index),
    .computed_crc(computed_crc),
    .stored_crc(stored_crc),
    .crc_match(crc_match),
    .image_good(image_good)
  );

  bicv_crc_checker u_check (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .image_byte(image_byte),
    .restart(restart),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .region_index(region_index),
    .computed_crc(computed_crc),
    .stored_crc(stored_crc),
    .crc_match(crc_match),
    .image_good(image_good),
    .reports_outstanding(reports_outstanding),
    .fail_count(fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (cfg_valid && cfg_ready) ||
        (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("banked_image_crc_verifier: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int run;
    forever begin
      run = $urandom_range(1, 40);
      repeat (run) @(posedge clk);
      if (!calm && $urandom_range(0, 1) == 1) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic first);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_valid <= 1'b1;
    image_byte <= b;
    restart    <= first;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Waits until every report has come out, then lets the pipeline drain.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (reports_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_settings(input logic [15:0] cl, input logic [15:0] so,
                                input logic [15:0] bl, input logic [3:0] bc);
    common_bytes = cl;
    skip_len   = so;
    bank_len   = bl;
    bank_cnt   = bc;
    write_reg(REG_COMMON_LENGTH, cl);
    write_reg(REG_SKIP_OFFSET, so);
    write_reg(REG_BANK_LENGTH, bl);
    write_reg(REG_BANK_COUNT, {12'd0, bc});
    cfg_valid <= 1'b0;
  endtask

  // Builds one image with the right CRC of every region whose header slot it holds, then
  // optionally damages one word or cuts the image short before sending it.
  task automatic send_image(input int flaw, input bit pin_extremes);
    logic [7:0]  img [$];
    logic [15:0] c;
    int clen, blen, regions, total, start, stop, cut, r, i;
    clen = (common_bytes == 16'd0) ? 65536 : int'(common_bytes);
    blen = (bank_len == 16'd0) ? 65536 : int'(bank_len);
    if (bank_cnt == 4'd0) regions = 1;
    else if (int'(bank_cnt) > MaxRegions) regions = MaxRegions;
    else regions = int'(bank_cnt);
    total = clen + (regions - 1) * blen;
    repeat (total) img.push_back(8'($urandom));
    if (pin_extremes) begin
      img[total - 2] = 8'h00;
      img[total - 1] = 8'hFF;
    end
    for (r = 0; r < regions; r++) begin
      start = (r == 0) ? int'(skip_len) : clen + (r - 1) * blen;
      stop  = (r == 0) ? clen : start + blen;
      c = 16'h0000;
      for (i = start; i < stop; i++) begin
        c = c ^ {8'h00, img[i]};
        repeat (8) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      end
      // With a short common region the header slot lies outside it; leave it alone.
      if (2 * r + 1 < clen) begin
        img[2 * r]     = c[7:0];
        img[2 * r + 1] = c[15:8];
      end
    end
    if (flaw == FlawCorrupt) begin
      cut = $urandom_range(0, total - 1);
      img[cut] ^= 8'($urandom_range(1, 255));
    end else if (flaw == FlawTruncate && total > 1) begin
      total = $urandom_range(1, total - 1);
    end
    for (i = 0; i < total; i++) push_byte(img[i], i == 0);
    image_bytes_sent += total;
  endtask

  task automatic random_phase();
    logic [15:0] cl, so, bl;
    logic [3:0]  bc;
    int roll, junk;
    cl = 16'($urandom_range(17, 40));
    so = 16'($urandom_range(16, 24));
    bl = 16'($urandom_range(1, 20));
    bc = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0: so = 16'($urandom_range(0, 15));          // header words feed the CRC
      1: so = cl + 16'($urandom_range(0, 6));      // nothing of the common region is summed
      2: cl = 16'($urandom_range(1, 16));          // header kept from earlier images
      3: begin
        bl = 16'($urandom_range(40, 60));
        bc = 4'($urandom_range(1, 3));
      end
      default: ;
    endcase
    gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
    settle();
    write_settings(cl, so, bl, bc);
    repeat ($urandom_range(2, 4)) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        send_image(FlawNone, 1'b0);
        // Words after a finished image are dropped by the halted block.
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
      end else if (roll < 80) begin
        send_image(FlawCorrupt, 1'b0);
      end else if (roll < 92) begin
        send_image(FlawTruncate, 1'b0);
      end else begin
        junk = $urandom_range(1, 12);
        repeat (junk) push_byte(8'($urandom), $urandom_range(0, 5) == 0);
        image_bytes_sent += junk;
      end
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Shortest regions; the first image must fill the whole header.
    write_settings(16'd17, 16'd16, 16'd1, 4'd2);
    send_image(FlawNone, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    // A new image that is abandoned; the next phase restarts over it.
    push_byte(8'hA5, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    image_bytes_sent += 4;

    while (image_bytes_sent < ItemTarget - TailItems) random_phase();

    // Largest skip offset, far past the end of the common region.
    gap_odds = 4;
    settle();
    write_settings(16'd24, 16'd65535, 16'd3, 4'd2);
    send_image(FlawNone, 1'b0);

    settle();
    calm = 1'b1;
    write_settings(16'd20, 16'd16, 16'd5, 4'd8);
    send_image(FlawNone, 1'b0);
    send_image(FlawCorrupt, 1'b0);
    send_image(FlawNone, 1'b0);

    settle();
    if (fail_count == 0 && reports_outstanding == 0) begin
      $display("banked_image_crc_verifier: match");
    end else begin
      $display("banked_image_crc_verifier: mismatch");
    end
    $finish;
  end

endmodule
